@@ rtl/sbts_pkg.sv @@
// Shared constants for the smoothstep bilinear texel sampler.
// No dependencies; the top level, sbts_front and sbts_back refer to it by scoped names.
`default_nettype none
package sbts_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCALE_X     = 3'd0;
  localparam logic [2:0] REG_SCALE_Z     = 3'd1;
  localparam logic [2:0] REG_SHIFT_X     = 3'd2;
  localparam logic [2:0] REG_SHIFT_Z     = 3'd3;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;

  // Operation codes of an input word.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Queue depths between the front, the back and the result port.
  localparam int JOB_DEPTH    = 16;
  localparam int RESULT_DEPTH = 8;

  // Blend weights run from 0 to 1.0 in Q1.16, so they need 17 bits.
  localparam int WEIGHT_W = 17;

  localparam logic [17:0] THREE_Q16 = 18'd196608;
  localparam logic [49:0] ROUND_Q32 = 50'h0_8000_0000;
  localparam int          HALF_Q16  = 32768;

endpackage
`default_nettype wire

@@ rtl/smoothstep_bilinear_texel_sampler.sv @@
// Smoothstep bilinear texel sampler, top level.
// Uses sbts_pkg, sbts_front, sbts_fifo and sbts_back.
//
// Input words enter through push/full; a word is taken when push is high and
// full is low. A write word stores one RGB texel and gives no result. A sample
// word gives one color word, read from empty/pop in input order.
// Configuration registers are written through cfg_write/cfg_index/cfg_data;
// the user must do so only while the block is idle, which the block itself
// does not enforce; indexes beyond the list are ignored. Throughput is one
// word per cycle while full is low. A sample's color passes the 8 front stages
// (multiply, saturate, four-stage wrap modulo, cell address), the job queue,
// the texel read, two blend stages and the result queue.
// The four corner texels are read together from four copies of the texel store;
// a write updates all copies.
// When the receiver stalls, up to 8 color words wait in the result queue, and
// up to 16 words wait in the front stages and the job queue together; full
// rises once those 16 places are taken.
// Reset empties both queues and the pipelines and loads the register reset
// values; the texel store is not cleared and must be written before reading.
`default_nettype none
module smoothstep_bilinear_texel_sampler #(
  parameter int MAX_DIM      = 128,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               operation,
  input  wire logic signed [31:0] coord_x,
  input  wire logic signed [31:0] coord_z,
  input  wire logic [13:0]        texel_index,
  input  wire logic [15:0]        texel_red,
  input  wire logic [15:0]        texel_green,
  input  wire logic [15:0]        texel_blue,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             color_red,
  output logic [15:0]             color_green,
  output logic [15:0]             color_blue,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int PW    = $clog2(MAX_DIM);
  localparam int CW    = CHANNEL_BITS;
  localparam int WW    = sbts_pkg::WEIGHT_W;
  localparam int JQ    = sbts_pkg::JOB_DEPTH;
  localparam int FCW   = $clog2(JQ + 1);
  localparam int JOB_W = 2 + AW + 2 * WW + 3 * CW;

  logic signed [23:0] scale_x, scale_z;
  logic signed [31:0] shift_x, shift_z;
  logic [7:0]         grid_width, grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x     <= 24'sd65536;
      scale_z     <= 24'sd65536;
      shift_x     <= '0;
      shift_z     <= '0;
      grid_width  <= 8'd128;
      grid_height <= 8'd128;
    end else if (cfg_write) begin
      case (cfg_index)
        sbts_pkg::REG_SCALE_X:     scale_x     <= cfg_data[23:0];
        sbts_pkg::REG_SCALE_Z:     scale_z     <= cfg_data[23:0];
        sbts_pkg::REG_SHIFT_X:     shift_x     <= cfg_data;
        sbts_pkg::REG_SHIFT_Z:     shift_z     <= cfg_data;
        sbts_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[7:0];
        sbts_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] clamp_dim(input logic [7:0] r);
    if (r < 8'd2) begin
      return DW'(2);
    end else if (32'(r) > 32'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(r);
    end
  endfunction

  logic [DW-1:0] dim_w, dim_h;
  logic [PW-1:0] period_x, period_z;

  assign dim_w    = clamp_dim(grid_width);
  assign dim_h    = clamp_dim(grid_height);
  assign period_x = PW'(dim_w - DW'(1));
  assign period_z = PW'(dim_h - DW'(1));

  // Words taken but not yet handed from the job queue to the back end.
  logic [FCW-1:0] fcount;
  logic           accept;
  logic           job_pop;

  assign full   = (fcount == FCW'(JQ));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
    end else begin
      fcount <= fcount + FCW'(accept) - FCW'(job_pop);
    end
  end

  logic          f_valid, f_write, f_en;
  logic [AW-1:0] f_addr;
  logic [WW-1:0] f_sx, f_sz;
  logic [CW-1:0] f_red, f_green, f_blue;

  sbts_front #(.MAX_DIM(MAX_DIM), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .operation   (operation),
    .coord_x     (coord_x),
    .coord_z     (coord_z),
    .texel_index (texel_index),
    .texel_red   (texel_red),
    .texel_green (texel_green),
    .texel_blue  (texel_blue),
    .scale_x     (scale_x),
    .scale_z     (scale_z),
    .shift_x     (shift_x),
    .shift_z     (shift_z),
    .dim_w       (dim_w),
    .period_x    (period_x),
    .period_z    (period_z),
    .job_valid   (f_valid),
    .job_write   (f_write),
    .job_en      (f_en),
    .job_addr    (f_addr),
    .job_sx      (f_sx),
    .job_sz      (f_sz),
    .job_red     (f_red),
    .job_green   (f_green),
    .job_blue    (f_blue)
  );

  logic [JOB_W-1:0] job_q;
  logic             job_empty;

  sbts_fifo #(.WIDTH(JOB_W), .DEPTH(JQ)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   ({f_write, f_en, f_addr, f_sx, f_sz, f_red, f_green, f_blue}),
    .pop   (job_pop),
    .dout  (job_q),
    .empty (job_empty)
  );

  logic          res_push;
  logic [CW-1:0] res_red, res_green, res_blue;
  logic          res_taken;

  assign res_taken = pop && !empty;

  sbts_back #(.MAX_DIM(MAX_DIM), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (!job_empty),
    .job_write (job_q[JOB_W-1]),
    .job_en    (job_q[JOB_W-2]),
    .job_addr  (job_q[2*WW + 3*CW +: AW]),
    .job_sx    (job_q[WW + 3*CW +: WW]),
    .job_sz    (job_q[3*CW +: WW]),
    .job_red   (job_q[2*CW +: CW]),
    .job_green (job_q[CW +: CW]),
    .job_blue  (job_q[0 +: CW]),
    .dim_w     (dim_w),
    .res_taken (res_taken),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res_red   (res_red),
    .res_green (res_green),
    .res_blue  (res_blue)
  );

  logic [47:0] res_q;

  sbts_fifo #(.WIDTH(48), .DEPTH(sbts_pkg::RESULT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   ({16'(res_red), 16'(res_green), 16'(res_blue)}),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign color_red   = res_q[47:32];
  assign color_green = res_q[31:16];
  assign color_blue  = res_q[15:0];

endmodule
`default_nettype wire

@@ rtl/sbts_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module sbts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/sbts_fifo.sv @@
// Small register FIFO used for the job queue and the result queue.
// No dependencies; DEPTH must be a power of two.
`default_nettype none
module sbts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wptr;
  logic [PTRW-1:0]  rptr;
  logic [CNTW-1:0]  count;
  logic             do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTRW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PTRW'(1);
      end
      count <= count + CNTW'(push) - CNTW'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/sbts_wrap.sv @@
// Pipelined floor-modulo of a signed 16-bit cell index by the wrap period.
// Four stages of four restoring steps each; no dependencies.
`default_nettype none
module sbts_wrap #(
  parameter int PW = 7
) (
  input  wire logic               clk,
  input  wire logic signed [15:0] cell_idx,
  input  wire logic [PW-1:0]      period,
  output logic      [PW-1:0]      result
);

  localparam int STEPS = 4;
  localparam int BITS  = 4;

  function automatic logic [PW-1:0] mod_step(input logic [PW-1:0] rem,
                                             input logic [BITS-1:0] bits,
                                             input logic [PW-1:0] per);
    logic [PW:0] r;
    r = {1'b0, rem};
    for (int i = BITS - 1; i >= 0; i--) begin
      r = {r[PW-1:0], bits[i]};
      if (r >= {1'b0, per}) begin
        r = r - {1'b0, per};
      end
    end
    return r[PW-1:0];
  endfunction

  logic [15:0]   mag;
  logic [PW-1:0] rem_q [STEPS];
  logic [15:0]   mag_q [STEPS];
  logic          neg_q [STEPS];

  assign mag = cell_idx[15] ? 16'(-cell_idx) : 16'(cell_idx);

  always_ff @(posedge clk) begin
    rem_q[0] <= mod_step('0, mag[15 -: BITS], period);
    mag_q[0] <= mag;
    neg_q[0] <= cell_idx[15];
  end

  for (genvar j = 1; j < STEPS; j++) begin : g_stage
    always_ff @(posedge clk) begin
      rem_q[j] <= mod_step(rem_q[j-1], mag_q[j-1][15 - BITS * j -: BITS], period);
      mag_q[j] <= mag_q[j-1];
      neg_q[j] <= neg_q[j-1];
    end
  end

  // A negative index with a nonzero remainder folds back into the period.
  assign result = (neg_q[STEPS-1] && rem_q[STEPS-1] != '0) ?
                  period - rem_q[STEPS-1] : rem_q[STEPS-1];

endmodule
`default_nettype wire

@@ rtl/sbts_front.sv @@
// Front end: takes input words, maps sample coordinates to wrapped cells and
// smoothstep weights, and emits one job per word. Uses sbts_pkg and sbts_wrap.
`default_nettype none
module sbts_front #(
  parameter int MAX_DIM      = 128,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                operation,
  input  wire logic signed [31:0]                  coord_x,
  input  wire logic signed [31:0]                  coord_z,
  input  wire logic [13:0]                         texel_index,
  input  wire logic [15:0]                         texel_red,
  input  wire logic [15:0]                         texel_green,
  input  wire logic [15:0]                         texel_blue,
  input  wire logic signed [23:0]                  scale_x,
  input  wire logic signed [23:0]                  scale_z,
  input  wire logic signed [31:0]                  shift_x,
  input  wire logic signed [31:0]                  shift_z,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]        dim_w,
  input  wire logic [$clog2(MAX_DIM)-1:0]          period_x,
  input  wire logic [$clog2(MAX_DIM)-1:0]          period_z,
  output logic                                     job_valid,
  output logic                                     job_write,
  output logic                                     job_en,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       job_addr,
  output logic [sbts_pkg::WEIGHT_W-1:0]            job_sx,
  output logic [sbts_pkg::WEIGHT_W-1:0]            job_sz,
  output logic [CHANNEL_BITS-1:0]                  job_red,
  output logic [CHANNEL_BITS-1:0]                  job_green,
  output logic [CHANNEL_BITS-1:0]                  job_blue
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int PW     = $clog2(MAX_DIM);
  localparam int CW     = CHANNEL_BITS;
  localparam int WW     = sbts_pkg::WEIGHT_W;
  localparam int PASS_W = 2 + AW + 3 * CW;
  localparam int STAGES = 8;

  // Scaled coordinate: floor to Q16.16, saturate, add the shift, saturate.
  function automatic logic signed [31:0] map_coord(input logic signed [55:0] prod,
                                                   input logic signed [31:0] shift);
    logic signed [39:0] q;
    logic signed [31:0] p;
    logic signed [32:0] sum;
    q = prod[55:16];
    if (q > 40'sd2147483647) begin
      p = 32'sh7fff_ffff;
    end else if (q < -40'sd2147483648) begin
      p = 32'sh8000_0000;
    end else begin
      p = q[31:0];
    end
    sum = {p[31], p} + {shift[31], shift};
    if (sum[32] != sum[31]) begin
      map_coord = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      map_coord = sum[31:0];
    end
  endfunction

  logic [STAGES:1]    vld;
  logic [PASS_W-1:0]  pass_q [1:STAGES];
  logic               wr_ok;

  logic signed [55:0] prod_x1, prod_z1;
  logic signed [31:0] p_x2, p_z2;
  logic [31:0]        ff_x3, ff_z3;
  logic [17:0]        u_x3, u_z3;
  logic [49:0]        tu_x4, tu_z4;
  logic [49:0]        rnd_x, rnd_z;
  logic [WW-1:0]      sx_q [5:STAGES];
  logic [WW-1:0]      sz_q [5:STAGES];
  logic [PW-1:0]      cell_x6, cell_z6;
  logic [PW-1:0]      cell_x7, cell_z7;
  logic [PW+DW-1:0]   row_base;
  logic [AW-1:0]      base;
  logic [AW-1:0]      addr8;

  assign wr_ok = (32'(texel_index) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-1:1], in_valid};
    end
  end

  // Operation, write flag, write address and texel data ride along.
  always_ff @(posedge clk) begin
    pass_q[1] <= {operation, wr_ok, AW'(texel_index), CW'(texel_red),
                  CW'(texel_green), CW'(texel_blue)};
    for (int k = 2; k <= STAGES; k++) begin
      pass_q[k] <= pass_q[k-1];
    end
  end

  sbts_wrap #(.PW(PW)) u_wrap_x (
    .clk      (clk),
    .cell_idx (p_x2[31:16]),
    .period   (period_x),
    .result   (cell_x6)
  );

  sbts_wrap #(.PW(PW)) u_wrap_z (
    .clk      (clk),
    .cell_idx (p_z2[31:16]),
    .period   (period_z),
    .result   (cell_z6)
  );

  assign rnd_x    = tu_x4 + sbts_pkg::ROUND_Q32;
  assign rnd_z    = tu_z4 + sbts_pkg::ROUND_Q32;
  assign row_base = (PW+DW)'(cell_z7) * (PW+DW)'(dim_w);
  assign base     = AW'(row_base) + AW'(cell_x7);

  always_ff @(posedge clk) begin
    prod_x1 <= coord_x * scale_x;
    prod_z1 <= coord_z * scale_z;
    p_x2    <= map_coord(prod_x1, shift_x);
    p_z2    <= map_coord(prod_z1, shift_z);
    // Smoothstep 3f^2 - 2f^3 in two multiply stages.
    ff_x3   <= 32'(p_x2[15:0]) * 32'(p_x2[15:0]);
    ff_z3   <= 32'(p_z2[15:0]) * 32'(p_z2[15:0]);
    u_x3    <= sbts_pkg::THREE_Q16 - {1'b0, p_x2[15:0], 1'b0};
    u_z3    <= sbts_pkg::THREE_Q16 - {1'b0, p_z2[15:0], 1'b0};
    tu_x4   <= 50'(ff_x3) * 50'(u_x3);
    tu_z4   <= 50'(ff_z3) * 50'(u_z3);
    sx_q[5] <= rnd_x[32 +: WW];
    sz_q[5] <= rnd_z[32 +: WW];
    for (int k = 6; k <= STAGES; k++) begin
      sx_q[k] <= sx_q[k-1];
      sz_q[k] <= sz_q[k-1];
    end
    cell_x7 <= cell_x6;
    cell_z7 <= cell_z6;
    addr8   <= (pass_q[7][PASS_W-1] == sbts_pkg::OP_WRITE) ?
               pass_q[7][3*CW +: AW] : base;
  end

  assign job_valid = vld[STAGES];
  assign job_write = (pass_q[STAGES][PASS_W-1] == sbts_pkg::OP_WRITE);
  assign job_en    = pass_q[STAGES][PASS_W-2];
  assign job_addr  = addr8;
  assign job_sx    = sx_q[STAGES];
  assign job_sz    = sz_q[STAGES];
  assign job_red   = pass_q[STAGES][2*CW +: CW];
  assign job_green = pass_q[STAGES][CW +: CW];
  assign job_blue  = pass_q[STAGES][0 +: CW];

endmodule
`default_nettype wire

@@ rtl/sbts_back.sv @@
// Back end: applies texel writes and, for samples, reads four texel copies and
// blends them. Uses sbts_pkg and sbts_ram.
`default_nettype none
module sbts_back #(
  parameter int MAX_DIM      = 128,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                job_avail,
  input  wire logic                                job_write,
  input  wire logic                                job_en,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  job_addr,
  input  wire logic [sbts_pkg::WEIGHT_W-1:0]       job_sx,
  input  wire logic [sbts_pkg::WEIGHT_W-1:0]       job_sz,
  input  wire logic [CHANNEL_BITS-1:0]             job_red,
  input  wire logic [CHANNEL_BITS-1:0]             job_green,
  input  wire logic [CHANNEL_BITS-1:0]             job_blue,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]        dim_w,
  input  wire logic                                res_taken,
  output logic                                     job_pop,
  output logic                                     res_push,
  output logic [CHANNEL_BITS-1:0]                  res_red,
  output logic [CHANNEL_BITS-1:0]                  res_green,
  output logic [CHANNEL_BITS-1:0]                  res_blue
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = CHANNEL_BITS;
  localparam int WW    = sbts_pkg::WEIGHT_W;
  localparam int OD    = sbts_pkg::RESULT_DEPTH;
  localparam int CNTW  = $clog2(OD + 1);
  localparam int MW    = CW + WW + 2;

  // a + (b - a) * s / 2^16 rounded, equal to a * (1 - s) + b * s rounded.
  function automatic logic [CW-1:0] lerp(input logic [CW-1:0] a,
                                         input logic [CW-1:0] b,
                                         input logic [WW-1:0] s);
    logic signed [CW:0]   d;
    logic signed [MW-1:0] m;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    m = d * $signed({1'b0, s});
    m = m + $signed(MW'(sbts_pkg::HALF_Q16));
    return a + m[16 +: CW];
  endfunction

  logic [CNTW-1:0] count;
  logic            take;
  logic [AW-1:0]   raddr [4];
  logic [3*CW-1:0] rdata [4];
  logic [CW-1:0]   tex [4][3];
  logic            v1, v2, v3;
  logic [WW-1:0]   sx1, sz1, sz2;
  logic [CW-1:0]   row0_2 [3];
  logic [CW-1:0]   row1_2 [3];
  logic [CW-1:0]   res3 [3];

  // Samples hold a place in the result queue from here until delivery.
  assign take    = job_avail && (job_write || count < CNTW'(OD));
  assign job_pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CNTW'(take && !job_write) - CNTW'(res_taken);
    end
  end

  assign raddr[0] = job_addr;
  assign raddr[1] = job_addr + AW'(1);
  assign raddr[2] = job_addr + AW'(dim_w);
  assign raddr[3] = job_addr + AW'(dim_w) + AW'(1);

  // Four identical copies give the four corner texels together.
  for (genvar k = 0; k < 4; k++) begin : g_copy
    sbts_ram #(.WIDTH(3 * CW), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (take && job_write && job_en),
      .waddr (job_addr),
      .wdata ({job_red, job_green, job_blue}),
      .raddr (raddr[k]),
      .rdata (rdata[k])
    );
    for (genvar c = 0; c < 3; c++) begin : g_ch
      assign tex[k][c] = rdata[k][CW * (3 - c) - 1 -: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take && !job_write;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sx1 <= job_sx;
    sz1 <= job_sz;
    sz2 <= sz1;
    for (int c = 0; c < 3; c++) begin
      row0_2[c] <= lerp(tex[0][c], tex[1][c], sx1);
      row1_2[c] <= lerp(tex[2][c], tex[3][c], sx1);
      res3[c]   <= lerp(row0_2[c], row1_2[c], sz2);
    end
  end

  assign res_push  = v3;
  assign res_red   = res3[0];
  assign res_green = res3[1];
  assign res_blue  = res3[2];

endmodule
`default_nettype wire
